>>> sv/e2b_pkg.sv
// Types, constants and helper functions for the Euler-rate to body-rate converter.
`default_nettype none
package e2b_pkg;

    localparam int TAB_LEN = 24;
    localparam int XY_W    = 34;
    localparam int Z_W     = 33;
    localparam int PR_W    = 68;
    localparam int RP_W    = 50;
    localparam int SUM_W   = 56;

    localparam logic signed [16:0]   QUARTER_TURN = 17'sd11520;
    localparam logic signed [16:0]   HALF_TURN    = 17'sd23040;
    localparam logic signed [XY_W-1:0] GAIN_Q30   = 34'sd652032874;
    localparam logic signed [SUM_W-1:0] HALF_LSB  = 56'sd536870912;

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] earth_roll_rate;
        logic signed [15:0] earth_pitch_rate;
        logic signed [15:0] earth_yaw_rate;
    } t_in;

    typedef struct packed {
        logic signed [15:0] body_roll_rate;
        logic signed [15:0] body_pitch_rate;
        logic signed [15:0] body_yaw_rate;
    } t_out;

    typedef struct packed {
        logic signed [15:0] dphi;
        logic signed [15:0] dtheta;
        logic signed [15:0] dpsi;
    } t_rates;

    typedef struct packed {
        logic                  flip;
        logic signed [Z_W-1:0] z;
    } t_fold;

    function automatic logic signed [Z_W-1:0] atan_f(input int unsigned i);
        logic signed [Z_W-1:0] v;
        case (i)
            0:       v = 33'sd377487360;
            1:       v = 33'sd222843801;
            2:       v = 33'sd117744544;
            3:       v = 33'sd59768969;
            4:       v = 33'sd30000467;
            5:       v = 33'sd15014858;
            6:       v = 33'sd7509261;
            7:       v = 33'sd3754860;
            8:       v = 33'sd1877459;
            9:       v = 33'sd938733;
            10:      v = 33'sd469367;
            11:      v = 33'sd234683;
            12:      v = 33'sd117342;
            13:      v = 33'sd58671;
            14:      v = 33'sd29335;
            15:      v = 33'sd14668;
            16:      v = 33'sd7334;
            17:      v = 33'sd3667;
            18:      v = 33'sd1833;
            19:      v = 33'sd917;
            20:      v = 33'sd458;
            21:      v = 33'sd229;
            22:      v = 33'sd115;
            23:      v = 33'sd57;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic t_fold fold_f(input logic signed [15:0] a);
        t_fold f;
        logic signed [16:0] w;
        w = 17'(a);
        f.flip = 1'b0;
        if (w > QUARTER_TURN) begin
            w = HALF_TURN - w;
            f.flip = 1'b1;
        end else if (w < -QUARTER_TURN) begin
            w = -HALF_TURN - w;
            f.flip = 1'b1;
        end
        f.z = {w, 16'b0};
        return f;
    endfunction

    function automatic logic signed [15:0] sat_f(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] r;
        r = (s + HALF_LSB) >>> 30;
        if (r > 56'sd32767) begin
            return 16'sh7fff;
        end else if (r < -56'sd32768) begin
            return 16'sh8000;
        end
        return r[15:0];
    endfunction

endpackage
`default_nettype wire

>>> sv/e2b_in_if.sv
// Input channel: angles and earth-frame rates with valid/ready handshake.
`default_nettype none
interface e2b_in_if;
    logic          valid;
    logic          ready;
    e2b_pkg::t_in  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/e2b_out_if.sv
// Output channel: body-frame rates with valid/ready handshake.
`default_nettype none
interface e2b_out_if;
    logic          valid;
    logic          ready;
    e2b_pkg::t_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/euler_rate_to_body_rate.sv
// Euler-angle rates to body angular rates: pipelined CORDIC sin/cos and rate transform.
// Usage:
//   i_in  carries roll and pitch angles (1/128 deg) and three earth-frame rates
//   (1/64 deg/s); o_out carries the three saturated body-frame rates.
//   One result transaction follows each input transaction, in order.
// Pipeline: N + 4 register stages, N = min(CORDIC_STAGES, 24): one fold stage, one
//   stage per CORDIC iteration, two multiply stages and a sum/round/saturate stage.
//   Iterations beyond 24 are not run.
// Throughput: one transaction per cycle unless stalled; each stage has a register.
// Stall: when the last stage holds a result that o_out does not take, the whole
//   pipeline holds and i_in.ready drops; nothing is lost or repeated.
//   While the last stage is empty or being taken, every stage advances.
// Reset: i_rst_n (synchronous, active low) clears all valid bits; payload
//   registers are not reset.
`default_nettype none
module euler_rate_to_body_rate #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    e2b_in_if.sink        i_in,
    e2b_out_if.source     o_out
);

    localparam int N    = (CORDIC_STAGES > e2b_pkg::TAB_LEN) ? e2b_pkg::TAB_LEN
                                                             : CORDIC_STAGES;
    localparam int LAST = N + 3;
    localparam int XW   = e2b_pkg::XY_W;
    localparam int ZW   = e2b_pkg::Z_W;
    localparam int PW   = e2b_pkg::PR_W;
    localparam int RW   = e2b_pkg::RP_W;
    localparam int SW   = e2b_pkg::SUM_W;

    logic r_vld [0:LAST];
    logic en;

    logic signed [XW-1:0] r_xa [0:N];
    logic signed [XW-1:0] r_ya [0:N];
    logic signed [ZW-1:0] r_za [0:N];
    logic                 r_fa [0:N];
    logic signed [XW-1:0] r_xb [0:N];
    logic signed [XW-1:0] r_yb [0:N];
    logic signed [ZW-1:0] r_zb [0:N];
    logic                 r_fb [0:N];
    e2b_pkg::t_rates      r_rt [0:N+2];

    logic signed [XW-1:0] sphi, cphi, sth, cth;
    logic signed [PW-1:0] r_sc_raw, r_cc_raw;
    logic signed [RW-1:0] r_sth_dpsi, r_cphi_dth, r_sphi_dth;
    logic signed [RW-1:0] r2_sth_dpsi, r2_cphi_dth, r2_sphi_dth;
    logic signed [PW-1:0] sc_w, cc_w;
    logic signed [SW-1:0] r_sc_dpsi, r_cc_dpsi;
    logic signed [SW-1:0] sum_p, sum_q, sum_r;
    e2b_pkg::t_out        r_out;
    e2b_pkg::t_fold       fa, fb;

    assign en          = !r_vld[LAST] || o_out.ready;
    assign i_in.ready  = en;
    assign o_out.valid = r_vld[LAST];
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LAST; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_in.valid;
            for (int k = 1; k <= LAST; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign fa = e2b_pkg::fold_f(i_in.data.roll_angle);
    assign fb = e2b_pkg::fold_f(i_in.data.pitch_angle);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_xa[0] <= e2b_pkg::GAIN_Q30;
            r_ya[0] <= '0;
            r_za[0] <= fa.z;
            r_fa[0] <= fa.flip;
            r_xb[0] <= e2b_pkg::GAIN_Q30;
            r_yb[0] <= '0;
            r_zb[0] <= fb.z;
            r_fb[0] <= fb.flip;
            r_rt[0] <= '{dphi:   i_in.data.earth_roll_rate,
                         dtheta: i_in.data.earth_pitch_rate,
                         dpsi:   i_in.data.earth_yaw_rate};
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (r_za[k] >= 0) begin
                    r_xa[k+1] <= r_xa[k] - (r_ya[k] >>> k);
                    r_ya[k+1] <= r_ya[k] + (r_xa[k] >>> k);
                    r_za[k+1] <= r_za[k] - e2b_pkg::atan_f(k);
                end else begin
                    r_xa[k+1] <= r_xa[k] + (r_ya[k] >>> k);
                    r_ya[k+1] <= r_ya[k] - (r_xa[k] >>> k);
                    r_za[k+1] <= r_za[k] + e2b_pkg::atan_f(k);
                end
                if (r_zb[k] >= 0) begin
                    r_xb[k+1] <= r_xb[k] - (r_yb[k] >>> k);
                    r_yb[k+1] <= r_yb[k] + (r_xb[k] >>> k);
                    r_zb[k+1] <= r_zb[k] - e2b_pkg::atan_f(k);
                end else begin
                    r_xb[k+1] <= r_xb[k] + (r_yb[k] >>> k);
                    r_yb[k+1] <= r_yb[k] - (r_xb[k] >>> k);
                    r_zb[k+1] <= r_zb[k] + e2b_pkg::atan_f(k);
                end
                r_fa[k+1] <= r_fa[k];
                r_fb[k+1] <= r_fb[k];
                r_rt[k+1] <= r_rt[k];
            end
        end
    end

    assign sphi = r_ya[N];
    assign cphi = r_fa[N] ? -r_xa[N] : r_xa[N];
    assign sth  = r_yb[N];
    assign cth  = r_fb[N] ? -r_xb[N] : r_xb[N];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sc_raw   <= PW'(sphi) * PW'(cth);
            r_cc_raw   <= PW'(cphi) * PW'(cth);
            r_sth_dpsi <= RW'(sth) * RW'(r_rt[N].dpsi);
            r_cphi_dth <= RW'(cphi) * RW'(r_rt[N].dtheta);
            r_sphi_dth <= RW'(sphi) * RW'(r_rt[N].dtheta);
            r_rt[N+1]  <= r_rt[N];
        end
    end

    assign sc_w = (r_sc_raw + PW'(e2b_pkg::HALF_LSB)) >>> 30;
    assign cc_w = (r_cc_raw + PW'(e2b_pkg::HALF_LSB)) >>> 30;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sc_dpsi   <= SW'(sc_w) * SW'(r_rt[N+1].dpsi);
            r_cc_dpsi   <= SW'(cc_w) * SW'(r_rt[N+1].dpsi);
            r2_sth_dpsi <= r_sth_dpsi;
            r2_cphi_dth <= r_cphi_dth;
            r2_sphi_dth <= r_sphi_dth;
            r_rt[N+2]   <= r_rt[N+1];
        end
    end

    assign sum_p = (SW'(r_rt[N+2].dphi) <<< 30) - SW'(r2_sth_dpsi);
    assign sum_q = SW'(r2_cphi_dth) + r_sc_dpsi;
    assign sum_r = r_cc_dpsi - SW'(r2_sphi_dth);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.body_roll_rate  <= e2b_pkg::sat_f(sum_p);
            r_out.body_pitch_rate <= e2b_pkg::sat_f(sum_q);
            r_out.body_yaw_rate   <= e2b_pkg::sat_f(sum_r);
        end
    end

endmodule
`default_nettype wire
